>>> sv/rcfh_pkg.sv
// Shared types and constants for the RTS/CTS frame handshake controller.
`default_nettype none

package rcfh_pkg;

  localparam int unsigned CmdW      = 3;
  localparam int unsigned KindW     = 3;
  localparam int unsigned ErrW      = 2;
  localparam int unsigned SessW     = 3;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned ShortW    = 8;
  localparam int unsigned LongW     = 16;
  localparam int unsigned WaitW     = 16;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [ShortW-1:0] ShortTimeoutRst = 8'd20;
  localparam logic [LongW-1:0]  LongTimeoutRst  = 16'd1000;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK       = 3'd0,
    CMD_PEER_REQ   = 3'd1,
    CMD_SEND_START = 3'd2,
    CMD_SEND_BYTE  = 3'd3,
    CMD_RX_BYTE    = 3'd4
  } cmd_e;

  typedef enum logic [KindW-1:0] {
    KIND_STATUS    = 3'd0,
    KIND_TX_BYTE   = 3'd1,
    KIND_RX_BYTE   = 3'd2,
    KIND_FRAME_END = 3'd3,
    KIND_ERROR     = 3'd4
  } kind_e;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE        = 2'd0,
    ERR_CTS_TIMEOUT = 2'd1,
    ERR_RTS_STUCK   = 2'd2,
    ERR_OVERFLOW    = 2'd3
  } err_e;

  typedef enum logic [SessW-1:0] {
    SESS_IDLE      = 3'd0,
    SESS_RX_WAIT   = 3'd1,
    SESS_RX_ACTIVE = 3'd2,
    SESS_TX_WAIT   = 3'd3,
    SESS_SENDING   = 3'd4,
    SESS_DRAIN     = 3'd5
  } sess_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SHORT_TIMEOUT = 1'b0,
    REG_LONG_TIMEOUT  = 1'b1
  } reg_e;

endpackage

`default_nettype wire

>>> sv/rts_cts_frame_handshake.sv
// Top level of the RTS/CTS frame handshake controller.
//
// Usage: each input transfer carries one command (tick, peer request, send
// start, send byte, received byte) with the sampled CTS level, a data byte and
// a final-byte flag. Every accepted command produces exactly one result
// transfer: a status, a byte to transmit, a forwarded received byte, a frame
// end with its length, or an error, together with the RTS and receiver-enable
// levels and the session phase after the command.
// The result is registered and valid in the cycle after the input transfer.
// Throughput: one command per cycle while each result is taken; the whole
// state update is a single registered step, and the result register is
// reloaded in the same cycle it is emptied.
// When the receiver stalls, the result register holds and in_ready_o stays
// low until it is taken.
// Reset puts the session in idle with RTS and the receiver off, the short
// timeout at 20 ticks and the long timeout at 1000 ticks.
// Configuration writes are always accepted and should be made while idle.
`default_nettype none

module rts_cts_frame_handshake #(
  parameter int unsigned MAX_FRAME = 1024,
  localparam int unsigned CntW = $clog2(MAX_FRAME + 1)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,

  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [rcfh_pkg::CmdW-1:0]      cmd_i,
  input  wire logic                           cts_i,
  input  wire logic [rcfh_pkg::ByteW-1:0]     byte_in_i,
  input  wire logic                           final_byte_i,

  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [rcfh_pkg::KindW-1:0]          kind_o,
  output logic                                rts_o,
  output logic                                rx_enable_o,
  output logic [rcfh_pkg::ByteW-1:0]          out_byte_o,
  output logic [CntW-1:0]                     frame_len_o,
  output logic [rcfh_pkg::ErrW-1:0]           error_code_o,
  output logic [rcfh_pkg::SessW-1:0]          session_o,

  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [rcfh_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [rcfh_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_FRAME);

  // Configuration registers.
  logic [rcfh_pkg::ShortW-1:0] short_q;
  logic [rcfh_pkg::LongW-1:0]  long_q;

  // Session state.
  rcfh_pkg::sess_e             phase_q, phase_d;
  logic [rcfh_pkg::WaitW-1:0]  wait_q, wait_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic                        sending_q, sending_d;
  logic                        rts_q, rts_d;
  logic                        rx_q, rx_d;

  // Result register.
  logic                        out_valid_q;
  rcfh_pkg::kind_e             kind_q, kind_d;
  logic [rcfh_pkg::ByteW-1:0]  obyte_q, obyte_d;
  logic [CntW-1:0]             flen_q, flen_d;
  rcfh_pkg::err_e              err_q, err_d;

  logic                        in_fire;
  logic                        start_chk;
  logic [rcfh_pkg::WaitW-1:0]  chk_base;
  logic [rcfh_pkg::WaitW-1:0]  chk_inc;
  logic [rcfh_pkg::WaitW-1:0]  drain_inc;
  logic [rcfh_pkg::WaitW-1:0]  short_lim;
  logic [rcfh_pkg::WaitW-1:0]  long_lim;
  logic                        drain_done;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // A zero timeout register behaves as one tick.
  assign short_lim = (short_q == '0) ? rcfh_pkg::WaitW'(1)
                                     : rcfh_pkg::WaitW'(short_q);
  assign long_lim  = (long_q == '0) ? rcfh_pkg::WaitW'(1) : long_q;
  assign chk_inc   = chk_base + rcfh_pkg::WaitW'(1);
  assign drain_inc = wait_q + rcfh_pkg::WaitW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q <= rcfh_pkg::ShortTimeoutRst;
      long_q  <= rcfh_pkg::LongTimeoutRst;
    end else if (cfg_valid_i) begin
      unique case (rcfh_pkg::reg_e'(cfg_index_i))
        rcfh_pkg::REG_SHORT_TIMEOUT: short_q <= cfg_data_i[rcfh_pkg::ShortW-1:0];
        rcfh_pkg::REG_LONG_TIMEOUT:  long_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d    = phase_q;
    wait_d     = wait_q;
    cnt_d      = cnt_q;
    sending_d  = sending_q;
    rts_d      = rts_q;
    rx_d       = rx_q;
    kind_d     = rcfh_pkg::KIND_STATUS;
    obyte_d    = '0;
    flen_d     = '0;
    err_d      = rcfh_pkg::ERR_NONE;
    start_chk  = 1'b0;
    chk_base   = '0;
    drain_done = !cts_i || (drain_inc >= long_lim);

    unique case (cmd_i)
      rcfh_pkg::CMD_TICK: begin
        if (phase_q == rcfh_pkg::SESS_RX_WAIT || phase_q == rcfh_pkg::SESS_TX_WAIT) begin
          start_chk = 1'b1;
          chk_base  = wait_q;
        end else if (phase_q == rcfh_pkg::SESS_RX_ACTIVE) begin
          if (!cts_i) begin
            kind_d    = rcfh_pkg::KIND_FRAME_END;
            flen_d    = cnt_q;
            err_d     = rts_q ? rcfh_pkg::ERR_RTS_STUCK : rcfh_pkg::ERR_NONE;
            phase_d   = rcfh_pkg::SESS_IDLE;
            rts_d     = 1'b0;
            rx_d      = 1'b0;
            sending_d = 1'b0;
            wait_d    = '0;
            cnt_d     = '0;
          end
        end else if (phase_q == rcfh_pkg::SESS_DRAIN) begin
          wait_d = drain_inc;
          if (drain_done) begin
            if (cnt_q != '0) begin
              kind_d = rcfh_pkg::KIND_FRAME_END;
              flen_d = cnt_q;
            end
            phase_d   = rcfh_pkg::SESS_IDLE;
            rts_d     = 1'b0;
            rx_d      = 1'b0;
            sending_d = 1'b0;
            wait_d    = '0;
            cnt_d     = '0;
          end
        end
      end
      rcfh_pkg::CMD_PEER_REQ: begin
        if (phase_q == rcfh_pkg::SESS_IDLE) begin
          rx_d      = 1'b1;
          cnt_d     = '0;
          phase_d   = rcfh_pkg::SESS_RX_WAIT;
          start_chk = 1'b1;
        end
      end
      rcfh_pkg::CMD_SEND_START: begin
        if (phase_q == rcfh_pkg::SESS_IDLE) begin
          sending_d = 1'b1;
          rx_d      = 1'b1;
          rts_d     = 1'b1;
          cnt_d     = '0;
          phase_d   = rcfh_pkg::SESS_TX_WAIT;
          start_chk = 1'b1;
        end
      end
      rcfh_pkg::CMD_SEND_BYTE: begin
        if (phase_q == rcfh_pkg::SESS_SENDING) begin
          kind_d  = rcfh_pkg::KIND_TX_BYTE;
          obyte_d = byte_in_i;
          if (final_byte_i) begin
            sending_d = 1'b0;
            rts_d     = 1'b0;
            wait_d    = '0;
            phase_d   = rcfh_pkg::SESS_DRAIN;
          end
        end
      end
      rcfh_pkg::CMD_RX_BYTE: begin
        if (rx_q) begin
          // The first byte of a receive frame releases RTS.
          if (cnt_q == '0 && !sending_q) begin
            rts_d = 1'b0;
          end
          if (cnt_q >= MaxCnt) begin
            kind_d = rcfh_pkg::KIND_ERROR;
            err_d  = rcfh_pkg::ERR_OVERFLOW;
          end else begin
            cnt_d   = cnt_q + CntW'(1);
            kind_d  = rcfh_pkg::KIND_RX_BYTE;
            obyte_d = byte_in_i;
          end
        end
      end
      default: ;
    endcase

    // CTS check while waiting for a session to start.
    if (start_chk) begin
      if (cts_i) begin
        if (phase_d == rcfh_pkg::SESS_RX_WAIT) begin
          rts_d   = 1'b1;
          phase_d = rcfh_pkg::SESS_RX_ACTIVE;
        end else begin
          phase_d = rcfh_pkg::SESS_SENDING;
        end
        wait_d = '0;
      end else if (chk_inc >= short_lim) begin
        kind_d    = rcfh_pkg::KIND_ERROR;
        err_d     = rcfh_pkg::ERR_CTS_TIMEOUT;
        phase_d   = rcfh_pkg::SESS_IDLE;
        rts_d     = 1'b0;
        rx_d      = 1'b0;
        sending_d = 1'b0;
        wait_d    = '0;
        cnt_d     = '0;
      end else begin
        wait_d = chk_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= rcfh_pkg::SESS_IDLE;
      wait_q    <= '0;
      cnt_q     <= '0;
      sending_q <= 1'b0;
      rts_q     <= 1'b0;
      rx_q      <= 1'b0;
    end else if (in_fire) begin
      phase_q   <= phase_d;
      wait_q    <= wait_d;
      cnt_q     <= cnt_d;
      sending_q <= sending_d;
      rts_q     <= rts_d;
      rx_q      <= rx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q  <= kind_d;
      obyte_q <= obyte_d;
      flen_q  <= flen_d;
      err_q   <= err_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign rts_o        = rts_q;
  assign rx_enable_o  = rx_q;
  assign out_byte_o   = obyte_q;
  assign frame_len_o  = flen_q;
  assign error_code_o = err_q;
  assign session_o    = phase_q;

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == rcfh_pkg::SESS_IDLE |-> !rts_q && !rx_q && !sending_q && cnt_q == '0)
    else $error("idle session with leftover state");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxCnt)
    else $error("received count beyond frame size");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == rcfh_pkg::KIND_ERROR && err_q == rcfh_pkg::ERR_OVERFLOW
    |-> cnt_q == MaxCnt)
    else $error("overflow reported with room in the frame");

  a_send_rts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == rcfh_pkg::SESS_SENDING |-> sending_q && rts_q)
    else $error("sending without RTS asserted");

endmodule

`default_nettype wire

>>> tb/sv/tb_rts_cts_frame_handshake.sv
// Self-checking testbench for the RTS/CTS frame handshake controller.
module tb_rts_cts_frame_handshake;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CmdW = rcfh_pkg::CmdW;
  localparam int unsigned KindW = rcfh_pkg::KindW;
  localparam int unsigned ErrW = rcfh_pkg::ErrW;
  localparam int unsigned SessW = rcfh_pkg::SessW;
  localparam int unsigned ByteW = rcfh_pkg::ByteW;
  localparam int unsigned ShortW = rcfh_pkg::ShortW;
  localparam int unsigned LongW = rcfh_pkg::LongW;
  localparam int unsigned WaitW = rcfh_pkg::WaitW;
  localparam int unsigned CfgIdxW = rcfh_pkg::CfgIdxW;
  localparam int unsigned CfgDataW = rcfh_pkg::CfgDataW;

  localparam int unsigned MaxFrame = 1024;
  localparam int unsigned LenW = $clog2(MaxFrame + 1);
  localparam int NumSegments = 6;
  localparam int SegmentItems = 16;
  localparam int HoldCycles = 400;
  localparam int StallLimit = 5000;
  localparam int MaxReports = 40;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             rts;
    logic             rx_enable;
    logic [ByteW-1:0] data;
    logic [LenW-1:0]  len;
    logic [ErrW-1:0]  err;
    logic [SessW-1:0] session;
  } reply_t;

  class session_scoreboard;
    logic [ShortW-1:0] short_limit = rcfh_pkg::ShortTimeoutRst;
    logic [LongW-1:0]  long_limit = rcfh_pkg::LongTimeoutRst;
    rcfh_pkg::sess_e   phase = rcfh_pkg::SESS_IDLE;
    logic [WaitW-1:0]  wait_ticks = '0;
    int unsigned       rx_count = 0;
    bit                sending = 1'b0;
    bit                rts = 1'b0;
    bit                rx_on = 1'b0;
    reply_t            pending_replies[$];
    int                errors = 0;
    int                accepted = 0;

    function void close_session();
      phase = rcfh_pkg::SESS_IDLE;
      rts = 1'b0;
      rx_on = 1'b0;
      sending = 1'b0;
      wait_ticks = '0;
      rx_count = 0;
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
      case (idx)
        rcfh_pkg::REG_SHORT_TIMEOUT: short_limit = value[ShortW-1:0];
        rcfh_pkg::REG_LONG_TIMEOUT:  long_limit = value[LongW-1:0];
        default: ;
      endcase
    endfunction

    // One CTS check while a session waits to start; a zero limit acts as one.
    function void check_start(bit cts, inout reply_t r);
      logic [WaitW-1:0] lim;
      if (cts) begin
        if (phase == rcfh_pkg::SESS_RX_WAIT) begin
          rts = 1'b1;
          phase = rcfh_pkg::SESS_RX_ACTIVE;
        end else begin
          phase = rcfh_pkg::SESS_SENDING;
        end
        wait_ticks = '0;
        return;
      end
      lim = (short_limit == 0) ? WaitW'(1) : WaitW'(short_limit);
      wait_ticks++;
      if (wait_ticks >= lim) begin
        close_session();
        r.kind = rcfh_pkg::KIND_ERROR;
        r.err = rcfh_pkg::ERR_CTS_TIMEOUT;
      end
    endfunction

    function void note_command(logic [CmdW-1:0] cmd, bit cts, logic [ByteW-1:0] data,
                               bit last);
      reply_t r;
      logic [WaitW-1:0] lim;
      bit done;
      r = '0;
      r.kind = rcfh_pkg::KIND_STATUS;
      r.err = rcfh_pkg::ERR_NONE;
      accepted++;
      case (cmd)
        rcfh_pkg::CMD_TICK: begin
          if (phase == rcfh_pkg::SESS_RX_WAIT || phase == rcfh_pkg::SESS_TX_WAIT) begin
            check_start(cts, r);
          end else if (phase == rcfh_pkg::SESS_RX_ACTIVE && !cts) begin
            r.kind = rcfh_pkg::KIND_FRAME_END;
            r.len = LenW'(rx_count);
            r.err = rts ? rcfh_pkg::ERR_RTS_STUCK : rcfh_pkg::ERR_NONE;
            close_session();
          end else if (phase == rcfh_pkg::SESS_DRAIN) begin
            done = !cts;
            if (!done) begin
              lim = (long_limit == 0) ? WaitW'(1) : WaitW'(long_limit);
              wait_ticks++;
              done = (wait_ticks >= lim);
            end
            if (done) begin
              if (rx_count != 0) begin
                r.kind = rcfh_pkg::KIND_FRAME_END;
                r.len = LenW'(rx_count);
              end
              close_session();
            end
          end
        end
        rcfh_pkg::CMD_PEER_REQ: begin
          if (phase == rcfh_pkg::SESS_IDLE) begin
            rx_on = 1'b1;
            wait_ticks = '0;
            rx_count = 0;
            phase = rcfh_pkg::SESS_RX_WAIT;
            check_start(cts, r);
          end
        end
        rcfh_pkg::CMD_SEND_START: begin
          if (phase == rcfh_pkg::SESS_IDLE) begin
            sending = 1'b1;
            rx_on = 1'b1;
            rts = 1'b1;
            wait_ticks = '0;
            rx_count = 0;
            phase = rcfh_pkg::SESS_TX_WAIT;
            check_start(cts, r);
          end
        end
        rcfh_pkg::CMD_SEND_BYTE: begin
          if (phase == rcfh_pkg::SESS_SENDING) begin
            r.kind = rcfh_pkg::KIND_TX_BYTE;
            r.data = data;
            if (last) begin
              sending = 1'b0;
              rts = 1'b0;
              wait_ticks = '0;
              phase = rcfh_pkg::SESS_DRAIN;
            end
          end
        end
        rcfh_pkg::CMD_RX_BYTE: begin
          if (rx_on) begin
            if (rx_count == 0 && !sending) rts = 1'b0;
            if (rx_count >= MaxFrame) begin
              r.kind = rcfh_pkg::KIND_ERROR;
              r.err = rcfh_pkg::ERR_OVERFLOW;
            end else begin
              rx_count++;
              r.kind = rcfh_pkg::KIND_RX_BYTE;
              r.data = data;
            end
          end
        end
        default: ;
      endcase
      r.rts = rts;
      r.rx_enable = rx_on;
      r.session = phase;
      pending_replies.push_back(r);
    endfunction

    function void report(string field, logic [15:0] want, logic [15:0] got);
      errors++;
      if (errors <= MaxReports) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("%0t: result of kind %0d with no command outstanding", $time, got.kind);
        end
        return;
      end
      want = pending_replies.pop_front();
      if (got.kind !== want.kind) report("kind", 16'(want.kind), 16'(got.kind));
      if (got.rts !== want.rts) report("rts", 16'(want.rts), 16'(got.rts));
      if (got.rx_enable !== want.rx_enable) begin
        report("rx_enable", 16'(want.rx_enable), 16'(got.rx_enable));
      end
      if (got.data !== want.data) report("out_byte", 16'(want.data), 16'(got.data));
      if (got.len !== want.len) report("frame_len", 16'(want.len), 16'(got.len));
      if (got.err !== want.err) report("error_code", 16'(want.err), 16'(got.err));
      if (got.session !== want.session) begin
        report("session", 16'(want.session), 16'(got.session));
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [CmdW-1:0]     cmd_i;
  logic                cts_i;
  logic [ByteW-1:0]    byte_in_i;
  logic                final_byte_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [KindW-1:0]    kind_o;
  logic                rts_o;
  logic                rx_enable_o;
  logic [ByteW-1:0]    out_byte_o;
  logic [LenW-1:0]     frame_len_o;
  logic [ErrW-1:0]     error_code_o;
  logic [SessW-1:0]    session_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  session_scoreboard sb = new;
  int tx_gap_pct = 0;
  int rx_stall_pct = 0;
  int stall_cycles = 0;
  int hold_left = 0;
  bit hold_go = 1'b0;
  bit hold_seen = 1'b0;

  rts_cts_frame_handshake #(
    .MAX_FRAME(MaxFrame)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .cts_i       (cts_i),
    .byte_in_i   (byte_in_i),
    .final_byte_i(final_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .rts_o       (rts_o),
    .rx_enable_o (rx_enable_o),
    .out_byte_o  (out_byte_o),
    .frame_len_o (frame_len_o),
    .error_code_o(error_code_o),
    .session_o   (session_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Commands are noted before results are checked, so the order within an edge is fixed.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_command(cmd_i, cts_i, byte_in_i, final_byte_i);
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_result(reply_t'{kind: kind_o, rts: rts_o, rx_enable: rx_enable_o,
                                 data: out_byte_o, len: frame_len_o, err: error_code_o,
                                 session: session_o});
      end
      if (cfg_valid_i && cfg_ready_o) sb.set_register(cfg_index_i, cfg_data_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
  end

  // The result side stalls at random, or for a long stretch on request.
  always @(negedge clk_i) begin
    if (hold_go != hold_seen) begin
      hold_seen = hold_go;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  initial begin
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("FAIL rts_cts_frame_handshake");
    $finish;
  end

  function automatic logic [ByteW-1:0] any_byte();
    return ByteW'($urandom_range(255));
  endfunction

  function automatic logic any_bit();
    return 1'($urandom_range(1));
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic issue(input logic [CmdW-1:0] cmd, input logic cts,
                       input logic [ByteW-1:0] data, input logic last);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    cts_i <= cts;
    byte_in_i <= data;
    final_byte_i <= last;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    @(negedge clk_i);
  endtask

  task automatic tick(input logic cts);
    issue(rcfh_pkg::CMD_TICK, cts, any_byte(), any_bit());
  endtask

  task automatic rx_byte();
    issue(rcfh_pkg::CMD_RX_BYTE, any_bit(), any_byte(), any_bit());
  endtask

  task automatic write_timeouts(input logic [ShortW-1:0] short_ticks,
                                input logic [LongW-1:0] long_ticks);
    logic [CfgDataW-1:0] word;
    word = CfgDataW'($urandom);
    word[ShortW-1:0] = short_ticks;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= rcfh_pkg::REG_SHORT_TIMEOUT;
    cfg_data_i <= word;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    @(negedge clk_i);
    cfg_index_i <= rcfh_pkg::REG_LONG_TIMEOUT;
    cfg_data_i <= long_ticks;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic await_replies();
    in_valid_i <= 1'b0;
    while (sb.pending_replies.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // Brings the session back to idle so that the next session can open.
  task automatic wind_down();
    while (sb.phase != rcfh_pkg::SESS_IDLE) begin
      if (sb.phase == rcfh_pkg::SESS_SENDING) begin
        issue(rcfh_pkg::CMD_SEND_BYTE, any_bit(), any_byte(), 1'b1);
      end else begin
        tick(1'b0);
      end
    end
  endtask

  task automatic rx_session();
    int waits;
    waits = ($urandom_range(7) == 0) ? int'(sb.short_limit) + 1 : $urandom_range(3);
    issue(rcfh_pkg::CMD_PEER_REQ, waits == 0, any_byte(), any_bit());
    for (int i = 1; i < waits && sb.phase == rcfh_pkg::SESS_RX_WAIT; i++) tick(1'b0);
    if (sb.phase == rcfh_pkg::SESS_RX_WAIT) tick(1'b1);
    if (sb.phase != rcfh_pkg::SESS_RX_ACTIVE) return;
    repeat ($urandom_range(6)) begin
      case ($urandom_range(5))
        0: tick(1'b1);
        1: issue(rcfh_pkg::CMD_SEND_START, any_bit(), any_byte(), any_bit());
        default: rx_byte();
      endcase
    end
    if (sb.phase == rcfh_pkg::SESS_RX_ACTIVE) tick(1'b0);
  endtask

  task automatic tx_session();
    int waits;
    int nbytes;
    int linger;
    waits = ($urandom_range(7) == 0) ? int'(sb.short_limit) + 1 : $urandom_range(3);
    issue(rcfh_pkg::CMD_SEND_START, waits == 0, any_byte(), any_bit());
    for (int i = 1; i < waits && sb.phase == rcfh_pkg::SESS_TX_WAIT; i++) tick(1'b0);
    if (sb.phase == rcfh_pkg::SESS_TX_WAIT) tick(1'b1);
    if (sb.phase != rcfh_pkg::SESS_SENDING) return;
    nbytes = $urandom_range(1, 6);
    for (int i = 1; i <= nbytes; i++) begin
      if ($urandom_range(2) == 0) rx_byte();
      if ($urandom_range(4) == 0) tick(any_bit());
      issue(rcfh_pkg::CMD_SEND_BYTE, any_bit(), any_byte(), i == nbytes);
    end
    // Sometimes CTS stays up long enough for the release wait to run out.
    linger = ($urandom_range(3) == 0 && sb.long_limit <= 64) ?
             int'(sb.long_limit) + 1 : $urandom_range(3);
    for (int i = 0; i < linger && sb.phase == rcfh_pkg::SESS_DRAIN; i++) begin
      if ($urandom_range(3) == 0) rx_byte();
      tick(1'b1);
    end
    if (sb.phase == rcfh_pkg::SESS_DRAIN) tick(1'b0);
  endtask

  task automatic run_traffic(input int n);
    int stop_at;
    stop_at = sb.accepted + n;
    while (sb.accepted < stop_at) begin
      case ($urandom_range(9))
        0, 1: issue(CmdW'($urandom_range(2 ** CmdW - 1)), any_bit(), any_byte(), any_bit());
        2, 3, 4, 5: begin
          wind_down();
          rx_session();
        end
        default: begin
          wind_down();
          tx_session();
        end
      endcase
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cmd_i = rcfh_pkg::CMD_TICK;
    cts_i = 1'b0;
    byte_in_i = '0;
    final_byte_i = 1'b0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = rcfh_pkg::REG_SHORT_TIMEOUT;
    cfg_data_i = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_timeouts(8'd2, 16'd3);
    issue(rcfh_pkg::CMD_RX_BYTE, 1'b0, 8'hFF, 1'b1);
    for (int c = int'(rcfh_pkg::CMD_RX_BYTE) + 1; c < 2 ** CmdW; c++) begin
      issue(CmdW'(c), 1'b1, 8'h00, 1'b0);
    end
    issue(rcfh_pkg::CMD_SEND_BYTE, 1'b1, 8'h55, 1'b1);
    issue(rcfh_pkg::CMD_PEER_REQ, 1'b1, any_byte(), any_bit());
    issue(rcfh_pkg::CMD_RX_BYTE, 1'b0, 8'h00, 1'b0);
    issue(rcfh_pkg::CMD_RX_BYTE, 1'b1, 8'hFF, 1'b1);
    tick(1'b1);
    tick(1'b0);
    // A frame that closes before any byte, with RTS still up, reports RTS stuck.
    issue(rcfh_pkg::CMD_PEER_REQ, 1'b1, any_byte(), any_bit());
    tick(1'b0);
    issue(rcfh_pkg::CMD_PEER_REQ, 1'b0, any_byte(), any_bit());
    tick(1'b0);
    // A byte received while sending must not drop RTS.
    issue(rcfh_pkg::CMD_SEND_START, 1'b0, any_byte(), any_bit());
    tick(1'b1);
    issue(rcfh_pkg::CMD_RX_BYTE, 1'b1, 8'hA5, 1'b0);
    issue(rcfh_pkg::CMD_SEND_BYTE, 1'b0, 8'h00, 1'b0);
    issue(rcfh_pkg::CMD_SEND_BYTE, 1'b1, 8'hFF, 1'b1);
    issue(rcfh_pkg::CMD_PEER_REQ, 1'b1, any_byte(), any_bit());
    tick(1'b0);
    issue(rcfh_pkg::CMD_SEND_START, 1'b1, any_byte(), any_bit());
    issue(rcfh_pkg::CMD_SEND_BYTE, 1'b0, 8'h3C, 1'b1);
    repeat (3) tick(1'b1);
    await_replies();

    for (int s = 0; s < NumSegments; s++) begin
      tx_gap_pct = (s < 2) ? 36 : (s < 4) ? 64 : 0;
      rx_stall_pct = (s < 2) ? 64 : (s < 4) ? 36 : 0;
      case (s)
        0: write_timeouts(8'd3, 16'd5);
        1: write_timeouts(8'd1, 16'd1);
        2: write_timeouts('0, '0);
        3: write_timeouts(8'd255, 16'd2);
        4: write_timeouts(ShortW'($urandom_range(2, 12)), LongW'($urandom_range(2, 40)));
        default: write_timeouts(rcfh_pkg::ShortTimeoutRst, 16'd48);
      endcase
      if (s == 1) begin
        // Overrun the frame buffer, then close the frame.
        wind_down();
        issue(rcfh_pkg::CMD_PEER_REQ, 1'b1, any_byte(), any_bit());
        repeat (MaxFrame + 3) begin
          if ($urandom_range(31) == 0) tick(1'b1);
          rx_byte();
        end
        tick(1'b0);
      end
      if (s == 4) hold_go = ~hold_go;
      run_traffic(SegmentItems);
      if (s == NumSegments - 1) begin
        // CTS never releases, so the drain runs the full long timeout.
        wind_down();
        issue(rcfh_pkg::CMD_SEND_START, 1'b1, any_byte(), any_bit());
        issue(rcfh_pkg::CMD_SEND_BYTE, any_bit(), any_byte(), 1'b1);
        while (sb.phase == rcfh_pkg::SESS_DRAIN) tick(1'b1);
      end
      await_replies();
    end

    if (sb.errors == 0 && sb.pending_replies.size() == 0) begin
      $display("PASS rts_cts_frame_handshake");
    end else begin
      $display("FAIL rts_cts_frame_handshake");
    end
    $finish;
  end

endmodule
